// File: hw/rtl/lle_periodic_stencil_rhs_unit_defines.svh
// ----------------------------------------------------------------------------
// LLE stencil RHS unit assertion macros
// Shared concurrent assertion forms, compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef LLE_PERIODIC_STENCIL_RHS_UNIT_DEFINES_SVH
`define LLE_PERIODIC_STENCIL_RHS_UNIT_DEFINES_SVH

`ifndef SYNTH
`define LPSR_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("lpsr assertion failed");
`define LPSR_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("lpsr assertion failed");
`define LPSR_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("lpsr assertion failed");
`else
`define LPSR_ASSERT(lbl, clk, rstn, prop)
`define LPSR_ASSERT_SAME(lbl, clk, rstn, ante, cons)
`define LPSR_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// File: hw/rtl/lpsr_pkg.sv
// ----------------------------------------------------------------------------
// LLE stencil RHS package
// Widths, register indexes and the job record passed from front to back.
// ----------------------------------------------------------------------------
package lpsr_pkg;

    localparam int DATA_W      = 32;
    localparam int FRAC_W      = 24;
    localparam int LAP_W       = DATA_W + 3;
    localparam int IDX_W       = 9;
    localparam int MAX_POINTS  = 512;
    localparam int CNT_W       = $clog2(MAX_POINTS);
    localparam int QUEUE_DEPTH = 4;
    localparam int CFG_IDX_W   = 2;

    localparam logic [CFG_IDX_W-1:0] REG_DETUNING  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PUMP      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DISP_GAIN = 2'd2;

    typedef struct packed {
        logic signed [DATA_W-1:0] detuning;
        logic signed [DATA_W-1:0] pump;
        logic signed [DATA_W-1:0] disp_gain;
    } cfg_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] u;
        logic signed [DATA_W-1:0] v;
        logic signed [LAP_W-1:0]  lap_u;
        logic signed [LAP_W-1:0]  lap_v;
        logic [IDX_W-1:0]         idx;
        logic                     run_end;
    } job_t;

endpackage

// File: hw/rtl/lpsr_front.sv
// ----------------------------------------------------------------------------
// LLE stencil RHS front end
// Accepts samples, keeps ring head and history, and issues stencil jobs.
// ----------------------------------------------------------------------------
`include "lle_periodic_stencil_rhs_unit_defines.svh"

module lpsr_front (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [lpsr_pkg::DATA_W-1:0]  s_sample_re,
    input  logic signed [lpsr_pkg::DATA_W-1:0]  s_sample_im,
    input  logic                                s_is_last,
    output logic                                job_valid,
    input  logic                                job_ready,
    output lpsr_pkg::job_t                      job
);

    localparam logic [1:0] JOB_INNER = 2'd0;
    localparam logic [1:0] JOB_TAIL  = 2'd1;
    localparam logic [1:0] JOB_WRAP  = 2'd2;

    localparam int DW = lpsr_pkg::DATA_W;
    localparam int LW = lpsr_pkg::LAP_W;
    localparam int CW = lpsr_pkg::CNT_W;

    logic [CW-1:0]        cnt_reg, cnt_next;
    logic [CW-1:0]        jidx_reg, jidx_next;
    logic [1:0]           pend_reg, pend_next;
    logic [1:0]           sel_reg, sel_next;
    logic signed [DW-1:0] h0u_reg, h0v_reg, h1u_reg, h1v_reg, h2u_reg, h2v_reg;
    logic signed [DW-1:0] hd0u_reg, hd0v_reg, hd1u_reg, hd1v_reg;

    logic                 accept, push, closing;
    logic signed [DW-1:0] pu, pv, cu, cv, nu, nv;

    assign accept  = s_valid && s_ready;
    assign push    = job_valid && job_ready;
    assign closing = s_is_last || (cnt_reg == CW'(lpsr_pkg::MAX_POINTS - 1));
    assign s_ready = (pend_reg == 2'd0) || ((pend_reg == 2'd1) && push);
    assign job_valid = (pend_reg != 2'd0);

    always_comb begin
        pu = h2u_reg;
        pv = h2v_reg;
        cu = h1u_reg;
        cv = h1v_reg;
        nu = h0u_reg;
        nv = h0v_reg;
        job.idx     = lpsr_pkg::IDX_W'(jidx_reg - CW'(1));
        job.run_end = 1'b0;
        case (sel_reg)
            JOB_INNER: begin
                pu = h2u_reg;
                pv = h2v_reg;
            end
            JOB_TAIL: begin
                pu = h1u_reg;
                pv = h1v_reg;
                cu = h0u_reg;
                cv = h0v_reg;
                nu = hd0u_reg;
                nv = hd0v_reg;
                job.idx = lpsr_pkg::IDX_W'(jidx_reg);
            end
            JOB_WRAP: begin
                pu = h0u_reg;
                pv = h0v_reg;
                cu = hd0u_reg;
                cv = hd0v_reg;
                nu = hd1u_reg;
                nv = hd1v_reg;
                job.idx     = '0;
                job.run_end = 1'b1;
            end
            default: begin
                pu = h2u_reg;
                pv = h2v_reg;
            end
        endcase
        job.u     = cu;
        job.v     = cv;
        job.lap_u = LW'(nu) - (LW'(cu) <<< 1) + LW'(pu);
        job.lap_v = LW'(nv) - (LW'(cv) <<< 1) + LW'(pv);
    end

    always_comb begin
        cnt_next  = cnt_reg;
        jidx_next = jidx_reg;
        pend_next = pend_reg;
        sel_next  = sel_reg;
        if (push) begin
            pend_next = pend_reg - 2'd1;
            sel_next  = sel_reg + 2'd1;
        end
        if (accept) begin
            cnt_next  = closing ? '0 : cnt_reg + CW'(1);
            jidx_next = cnt_reg;
            if (cnt_reg >= CW'(2)) begin
                pend_next = closing ? 2'd3 : 2'd1;
                sel_next  = JOB_INNER;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            pend_reg <= 2'd0;
            sel_reg  <= JOB_INNER;
            h0u_reg  <= '0;
            h0v_reg  <= '0;
            h1u_reg  <= '0;
            h1v_reg  <= '0;
            h2u_reg  <= '0;
            h2v_reg  <= '0;
            hd0u_reg <= '0;
            hd0v_reg <= '0;
            hd1u_reg <= '0;
            hd1v_reg <= '0;
        end else begin
            cnt_reg  <= cnt_next;
            pend_reg <= pend_next;
            sel_reg  <= sel_next;
            if (accept) begin
                h2u_reg <= h1u_reg;
                h2v_reg <= h1v_reg;
                h1u_reg <= h0u_reg;
                h1v_reg <= h0v_reg;
                h0u_reg <= s_sample_re;
                h0v_reg <= s_sample_im;
                if (cnt_reg == CW'(0)) begin
                    hd0u_reg <= s_sample_re;
                    hd0v_reg <= s_sample_im;
                end
                if (cnt_reg == CW'(1)) begin
                    hd1u_reg <= s_sample_re;
                    hd1v_reg <= s_sample_im;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        jidx_reg <= jidx_next;
    end

    `LPSR_ASSERT_NEXT(a_head_no_jobs, aclk, aresetn, accept && (cnt_reg < CW'(2)), pend_reg == 2'd0)
    `LPSR_ASSERT_NEXT(a_close_restarts, aclk, aresetn, accept && closing, cnt_reg == CW'(0))

endmodule

// File: hw/rtl/lpsr_queue.sv
// ----------------------------------------------------------------------------
// LLE stencil RHS job queue
// Small register FIFO that decouples the front end from the arithmetic.
// ----------------------------------------------------------------------------
`include "lle_periodic_stencil_rhs_unit_defines.svh"

module lpsr_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push_valid,
    output logic           push_ready,
    input  lpsr_pkg::job_t push_data,
    output logic           pop_valid,
    input  logic           pop_ready,
    output lpsr_pkg::job_t pop_data
);

    localparam int DEPTH = lpsr_pkg::QUEUE_DEPTH;
    localparam int PW    = $clog2(DEPTH);
    localparam int NW    = $clog2(DEPTH + 1);

    lpsr_pkg::job_t mem_reg [DEPTH];
    logic [PW-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [NW-1:0]  count_reg, count_next;
    logic           do_push, do_pop;

    assign push_ready = (count_reg != NW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign pop_data   = mem_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + NW'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - NW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + PW'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + PW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    `LPSR_ASSERT(a_count_bound, aclk, aresetn, count_reg <= NW'(DEPTH))
    `LPSR_ASSERT_SAME(a_ptr_gap, aclk, aresetn, (count_reg == '0) || (count_reg == NW'(DEPTH)), wr_ptr_reg == rd_ptr_reg)

endmodule

// File: hw/rtl/lpsr_back.sv
// ----------------------------------------------------------------------------
// LLE stencil RHS arithmetic back end
// Four-stage pipeline forming the derivative pair with an output register.
// ----------------------------------------------------------------------------
`include "lle_periodic_stencil_rhs_unit_defines.svh"

module lpsr_back (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  lpsr_pkg::cfg_t                     cfg,
    input  logic                               job_valid,
    output logic                               job_ready,
    input  lpsr_pkg::job_t                     job,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [lpsr_pkg::DATA_W-1:0] m_deriv_re,
    output logic signed [lpsr_pkg::DATA_W-1:0] m_deriv_im,
    output logic [lpsr_pkg::IDX_W-1:0]         m_point_index,
    output logic                               m_run_end
);

    localparam int DW  = lpsr_pkg::DATA_W;
    localparam int FW  = lpsr_pkg::FRAC_W;
    localparam int LW  = lpsr_pkg::LAP_W;
    localparam int IW  = lpsr_pkg::IDX_W;
    localparam int PW  = 2 * DW;
    localparam int QW  = PW - FW;
    localparam int LHW = LW - FW;
    localparam int GHW = DW + LHW;
    localparam int GLW = DW + FW + 1;
    localparam int GW  = GHW;
    localparam int MW  = QW + 1;
    localparam int MHW = MW - FW + 1;
    localparam int VHW = MHW + DW;
    localparam int VW  = VHW;
    localparam int SW  = GW + 1;
    localparam int OW  = VW + 2;

    function automatic logic signed [DW-1:0] sat_w(input logic signed [OW-1:0] x);
        logic signed [DW-1:0] r;
        if (x > OW'(signed'({1'b0, {(DW-1){1'b1}}}))) begin
            r = {1'b0, {(DW-1){1'b1}}};
        end else if (x < OW'(signed'({1'b1, {(DW-1){1'b0}}}))) begin
            r = {1'b1, {(DW-1){1'b0}}};
        end else begin
            r = DW'(x);
        end
        return r;
    endfunction

    logic adv;

    logic                 s1_vld_reg, s2_vld_reg, s3_vld_reg, out_vld_reg;
    logic [IW-1:0]        s1_idx_reg, s2_idx_reg, s3_idx_reg, out_idx_reg;
    logic                 s1_end_reg, s2_end_reg, s3_end_reg, out_end_reg;
    logic signed [DW-1:0] s1_u_reg, s1_v_reg, s2_u_reg, s2_v_reg;
    logic signed [QW-1:0] s1_uu_reg, s1_vv_reg, s1_dtu_reg, s1_dtv_reg;
    logic signed [GW-1:0] s1_glu_reg, s1_glv_reg;
    logic signed [MW-1:0] s2_mag_reg;
    logic signed [SW-1:0] s2_dup_reg, s2_dvp_reg, s3_dup_reg, s3_dvp_reg;
    logic signed [VW-1:0] s3_mu_reg, s3_mv_reg;
    logic signed [DW-1:0] out_re_reg, out_im_reg;

    logic signed [PW-1:0]  uu_p, vv_p, dtu_p, dtv_p;
    logic signed [LHW-1:0] lu_hi, lv_hi;
    logic signed [FW:0]    lu_lo, lv_lo;
    logic signed [GHW-1:0] gu_hi_p, gv_hi_p;
    logic signed [GLW-1:0] gu_lo_p, gv_lo_p;
    logic signed [MHW-1:0] mag_hi;
    logic signed [FW:0]    mag_lo;
    logic signed [VHW-1:0] mu_hi_p, mv_hi_p;
    logic signed [GLW-1:0] mu_lo_p, mv_lo_p;
    logic signed [OW-1:0]  du_sum, dv_sum;

    assign adv       = !out_vld_reg || m_ready;
    assign job_ready = adv;

    assign uu_p    = job.u * job.u;
    assign vv_p    = job.v * job.v;
    assign dtu_p   = cfg.detuning * job.u;
    assign dtv_p   = cfg.detuning * job.v;
    assign lu_hi   = job.lap_u[LW-1:FW];
    assign lv_hi   = job.lap_v[LW-1:FW];
    assign lu_lo   = signed'({1'b0, job.lap_u[FW-1:0]});
    assign lv_lo   = signed'({1'b0, job.lap_v[FW-1:0]});
    assign gu_hi_p = cfg.disp_gain * lu_hi;
    assign gv_hi_p = cfg.disp_gain * lv_hi;
    assign gu_lo_p = cfg.disp_gain * lu_lo;
    assign gv_lo_p = cfg.disp_gain * lv_lo;

    assign mag_hi  = signed'({1'b0, s2_mag_reg[MW-1:FW]});
    assign mag_lo  = signed'({1'b0, s2_mag_reg[FW-1:0]});
    assign mu_hi_p = mag_hi * s2_u_reg;
    assign mv_hi_p = mag_hi * s2_v_reg;
    assign mu_lo_p = mag_lo * s2_u_reg;
    assign mv_lo_p = mag_lo * s2_v_reg;

    assign du_sum = OW'(s3_dup_reg) - OW'(s3_mv_reg);
    assign dv_sum = OW'(s3_dvp_reg) + OW'(s3_mu_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            s3_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else if (adv) begin
            s1_vld_reg  <= job_valid;
            s2_vld_reg  <= s1_vld_reg;
            s3_vld_reg  <= s2_vld_reg;
            out_vld_reg <= s3_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_u_reg   <= job.u;
            s1_v_reg   <= job.v;
            s1_uu_reg  <= uu_p[PW-1:FW];
            s1_vv_reg  <= vv_p[PW-1:FW];
            s1_dtu_reg <= dtu_p[PW-1:FW];
            s1_dtv_reg <= dtv_p[PW-1:FW];
            s1_glu_reg <= gu_hi_p + GW'(signed'(gu_lo_p[GLW-1:FW]));
            s1_glv_reg <= gv_hi_p + GW'(signed'(gv_lo_p[GLW-1:FW]));
            s1_idx_reg <= job.idx;
            s1_end_reg <= job.run_end;

            s2_u_reg   <= s1_u_reg;
            s2_v_reg   <= s1_v_reg;
            s2_mag_reg <= MW'(s1_uu_reg) + MW'(s1_vv_reg);
            s2_dup_reg <= SW'(s1_dtv_reg) - SW'(s1_u_reg) - SW'(s1_glv_reg)
                          + SW'(cfg.pump);
            s2_dvp_reg <= SW'(s1_glu_reg) - SW'(s1_v_reg) - SW'(s1_dtu_reg);
            s2_idx_reg <= s1_idx_reg;
            s2_end_reg <= s1_end_reg;

            s3_mu_reg  <= mu_hi_p + VW'(signed'(mu_lo_p[GLW-1:FW]));
            s3_mv_reg  <= mv_hi_p + VW'(signed'(mv_lo_p[GLW-1:FW]));
            s3_dup_reg <= s2_dup_reg;
            s3_dvp_reg <= s2_dvp_reg;
            s3_idx_reg <= s2_idx_reg;
            s3_end_reg <= s2_end_reg;

            out_re_reg  <= sat_w(du_sum);
            out_im_reg  <= sat_w(dv_sum);
            out_idx_reg <= s3_idx_reg;
            out_end_reg <= s3_end_reg;
        end
    end

    assign m_valid       = out_vld_reg;
    assign m_deriv_re    = out_re_reg;
    assign m_deriv_im    = out_im_reg;
    assign m_point_index = out_idx_reg;
    assign m_run_end     = out_end_reg;

    `LPSR_ASSERT_NEXT(a_stage_moves, aclk, aresetn, adv && s3_vld_reg, out_vld_reg)
    `LPSR_ASSERT_NEXT(a_stall_holds, aclk, aresetn, !adv && s3_vld_reg, s3_vld_reg && out_vld_reg)

endmodule

// File: hw/rtl/lle_periodic_stencil_rhs_unit.sv
// ----------------------------------------------------------------------------
// LLE periodic stencil RHS unit
// Lugiato-Lefever time derivative over a ring with a three-point Laplacian.
// ----------------------------------------------------------------------------
// Samples enter on the s_ channel in ring order, with s_is_last on the final
// one. Result k leaves on the m_ channel when sample k+1 has been taken; the
// last sample releases results N-2, N-1 and then 0, the last with m_run_end.
// Rings of one or two samples give no results, and a ring that reaches 512
// samples closes as if marked. A plain sample is taken every cycle while the
// queue has room. A closing sample holds s_ready low until the last of its
// three jobs goes to the queue, one per cycle while it has room. Jobs pass
// the queue and the four pipeline stages s1, s2, s3 and the output register
// to the m_ channel. When the receiver stalls, the pipeline holds, the
// four-entry job queue fills and then s_ready drops. Registers are written
// through cfg_wr_en, cfg_index and cfg_wdata; writing only while the block
// is idle is up to the user, with no check in the block. Reset clears the
// ring position, the queue, the pipeline and all three registers to zero.
// ----------------------------------------------------------------------------

module lle_periodic_stencil_rhs_unit (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic signed [lpsr_pkg::DATA_W-1:0]    s_sample_re,
    input  logic signed [lpsr_pkg::DATA_W-1:0]    s_sample_im,
    input  logic                                  s_is_last,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [lpsr_pkg::DATA_W-1:0]    m_deriv_re,
    output logic signed [lpsr_pkg::DATA_W-1:0]    m_deriv_im,
    output logic [lpsr_pkg::IDX_W-1:0]            m_point_index,
    output logic                                  m_run_end,
    input  logic                                  cfg_wr_en,
    input  logic [lpsr_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [lpsr_pkg::DATA_W-1:0]           cfg_wdata
);

    lpsr_pkg::cfg_t cfg_reg;
    lpsr_pkg::job_t fr_job, q_job;
    logic           fr_valid, fr_ready, q_valid, q_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                lpsr_pkg::REG_DETUNING:  cfg_reg.detuning  <= cfg_wdata;
                lpsr_pkg::REG_PUMP:      cfg_reg.pump      <= cfg_wdata;
                lpsr_pkg::REG_DISP_GAIN: cfg_reg.disp_gain <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    lpsr_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_sample_re (s_sample_re),
        .s_sample_im (s_sample_im),
        .s_is_last   (s_is_last),
        .job_valid   (fr_valid),
        .job_ready   (fr_ready),
        .job         (fr_job)
    );

    lpsr_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (fr_valid),
        .push_ready (fr_ready),
        .push_data  (fr_job),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_data   (q_job)
    );

    lpsr_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg_reg),
        .job_valid     (q_valid),
        .job_ready     (q_ready),
        .job           (q_job),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_deriv_re    (m_deriv_re),
        .m_deriv_im    (m_deriv_im),
        .m_point_index (m_point_index),
        .m_run_end     (m_run_end)
    );

endmodule
